[rtl/core/pjdq_pkg.sv]
// pjdq_pkg: shared types and codes of the priority job dispatch queue
// used by pjdq_cell, priority_job_dispatch_queue and pjdq_checker
package pjdq_pkg;

  localparam logic REQ_SUBMIT   = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  localparam logic [1:0] ST_STORED     = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic [7:0]  rank;
    logic [15:0] pages;
    logic [15:0] ident;
    logic [1:0]  kind;
  } job_t;

  typedef struct packed {
    logic insert;
    logic remove;
    job_t job;
  } cell_ctrl_t;

endpackage

[rtl/core/pjdq_cell.sv]
// pjdq_cell: one slot of the sorted job row, holds one job and shifts with its neighbors
// depends on pjdq_pkg
module pjdq_cell (
  input  logic                  clk_i,
  input  pjdq_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  occupied_i,
  input  logic                  left_gt_i,
  input  pjdq_pkg::job_t        left_job_i,
  input  pjdq_pkg::job_t        right_job_i,
  output pjdq_pkg::job_t        job_o,
  output logic                  gt_o
);

  pjdq_pkg::job_t job_q;
  pjdq_pkg::job_t job_d;

  // a job with an equal key stays ahead of the new one
  assign gt_o = !occupied_i ||
                ({job_q.rank, job_q.pages} > {ctrl_i.job.rank, ctrl_i.job.pages});

  always_comb begin
    job_d = job_q;
    if (ctrl_i.insert && gt_o) begin
      job_d = left_gt_i ? left_job_i : ctrl_i.job;
    end else if (ctrl_i.remove) begin
      job_d = right_job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_o = job_q;

endmodule

[rtl/core/priority_job_dispatch_queue.sv]
// priority_job_dispatch_queue: top level, row of pjdq_cell slots kept sorted plus result register
// depends on pjdq_pkg and pjdq_cell
//
// Jobs sit in a row of DEPTH cells kept in serving order (rank, then pages, then submission
// order), so a submit is one parallel compare in every cell and a shift of the larger entries
// by one place, and a dispatch takes the head cell and shifts the row forward.
// Each result word lands in an output register; a new request is taken in the same cycle in
// which the waiting result is taken, so back-to-back requests flow at one per cycle when the
// sink does not stall. The store needs no clearing after reset: a fill count marks which
// cells hold jobs.
module priority_job_dispatch_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] job_ident_i,
  input  logic [15:0] page_count_i,
  input  logic [1:0]  job_kind_i,
  input  logic [7:0]  job_rank_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_ident_o,
  output logic [15:0] out_pages_o,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_rank_o,
  output logic [4:0]  waiting_count_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q;
  pjdq_pkg::job_t       res_q;
  logic [4:0]           wait_q;

  logic                 accept;
  logic                 is_submit;
  logic                 is_full;
  logic                 is_empty;
  pjdq_pkg::cell_ctrl_t ctrl;
  pjdq_pkg::job_t       cell_job [DEPTH];
  logic [DEPTH-1:0]     cell_gt;
  logic [1:0]           status_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_submit  = (req_type_i == pjdq_pkg::REQ_SUBMIT);
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);

  assign ctrl.insert    = accept && is_submit && !is_full;
  assign ctrl.remove    = accept && !is_submit && !is_empty;
  assign ctrl.job.rank  = job_rank_i;
  assign ctrl.job.pages = page_count_i;
  assign ctrl.job.ident = job_ident_i;
  assign ctrl.job.kind  = job_kind_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           left_gt;
    pjdq_pkg::job_t left_job;
    pjdq_pkg::job_t right_job;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_job = ctrl.job;
    end else begin : g_mid
      assign left_gt  = cell_gt[i-1];
      assign left_job = cell_job[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_job = '0;
    end else begin : g_inner
      assign right_job = cell_job[i+1];
    end

    pjdq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CW'(i) < count_q),
      .left_gt_i   (left_gt),
      .left_job_i  (left_job),
      .right_job_i (right_job),
      .job_o       (cell_job[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    if (is_submit) begin
      status_d = is_full ? pjdq_pkg::ST_FULL : pjdq_pkg::ST_STORED;
    end else begin
      status_d = is_empty ? pjdq_pkg::ST_EMPTY : pjdq_pkg::ST_DISPATCHED;
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= ctrl.remove ? cell_job[0] : '0;
      wait_q   <= 5'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_ident_o     = res_q.ident;
  assign out_pages_o     = res_q.pages;
  assign out_kind_o      = res_q.kind;
  assign out_rank_o      = res_q.rank;
  assign waiting_count_o = wait_q;

endmodule

[rtl/core/pjdq_checker.sv]
// pjdq_checker: port-level assertions on the priority job dispatch queue, bound to the top level
// depends on pjdq_pkg and priority_job_dispatch_queue
module pjdq_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] out_ident_o,
  input logic [15:0] out_pages_o,
  input logic [1:0]  out_kind_o,
  input logic [7:0]  out_rank_o,
  input logic [4:0]  waiting_count_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(waiting_count_o))
    else $error("result word dropped while stalled");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pjdq_pkg::ST_EMPTY |->
      waiting_count_o == 5'd0 && out_ident_o == 16'd0 && out_pages_o == 16'd0 &&
      out_kind_o == 2'd0 && out_rank_o == 8'd0)
    else $error("empty dispatch with nonzero fields");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pjdq_pkg::ST_FULL |-> waiting_count_o == 5'(DEPTH))
    else $error("full reject without a full store");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 31) || (int'(waiting_count_o) <= DEPTH))
    else $error("waiting count above depth");

  // a submitted job that is stored cannot leave an empty store
  a_stored_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pjdq_pkg::ST_STORED |->
      (DEPTH > 31) || waiting_count_o != 5'd0)
    else $error("stored job with empty store");

endmodule

bind priority_job_dispatch_queue pjdq_checker #(.DEPTH(DEPTH)) u_pjdq_checker (.*);

[test/priority_job_dispatch_queue_tb.sv]
// priority_job_dispatch_queue_tb: self-checking bench for the priority job dispatch queue
// drives submit and dispatch words with random idling, predicts every result word in a
// scoreboard class and compares field by field; depends on pjdq_pkg and the queue rtl
module priority_job_dispatch_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 1800;
  localparam int QUIET_WORDS  = 200;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ident;
    logic [15:0] pages;
    logic [1:0]  kind;
    logic [7:0]  rank;
    logic [4:0]  waiting;
  } reply_t;

  class dispatch_board;
    pjdq_pkg::job_t held_jobs[$];
    reply_t         due_replies[$];
    int             errors = 0;

    function void note_request(logic req, pjdq_pkg::job_t job);
      reply_t r;
      int     pick;
      int     k;
      r = '0;
      if (req == pjdq_pkg::REQ_SUBMIT) begin
        if (held_jobs.size() < DEPTH) begin
          held_jobs.push_back(job);
          r.status = pjdq_pkg::ST_STORED;
        end else begin
          r.status = pjdq_pkg::ST_FULL;
        end
      end else if (held_jobs.size() == 0) begin
        r.status = pjdq_pkg::ST_EMPTY;
      end else begin
        pick = 0;
        // strict compare keeps the earliest submitted job on a full tie
        for (k = 1; k < held_jobs.size(); k++) begin
          if (held_jobs[k].rank < held_jobs[pick].rank ||
              (held_jobs[k].rank == held_jobs[pick].rank &&
               held_jobs[k].pages < held_jobs[pick].pages))
            pick = k;
        end
        r.status = pjdq_pkg::ST_DISPATCHED;
        r.ident  = held_jobs[pick].ident;
        r.pages  = held_jobs[pick].pages;
        r.kind   = held_jobs[pick].kind;
        r.rank   = held_jobs[pick].rank;
        held_jobs.delete(pick);
      end
      r.waiting = 5'(held_jobs.size());
      due_replies.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        $error("result word with no expectation waiting: %p", got);
        errors++;
      end else begin
        want = due_replies.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("out_ident", want.ident, got.ident);
        compare_field("out_pages", want.pages, got.pages);
        compare_field("out_kind", want.kind, got.kind);
        compare_field("out_rank", want.rank, got.rank);
        compare_field("waiting_count", want.waiting, got.waiting);
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        req_type_i      = pjdq_pkg::REQ_SUBMIT;
  logic [15:0] job_ident_i     = '0;
  logic [15:0] page_count_i    = '0;
  logic [1:0]  job_kind_i      = '0;
  logic [7:0]  job_rank_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_ident_o;
  logic [15:0] out_pages_o;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_rank_o;
  logic [4:0]  waiting_count_o;

  dispatch_board board;
  int gap_odds      = 20;
  int stall_odds    = 20;
  bit long_hold_req = 1'b0;
  int cycle_count   = 0;

  priority_job_dispatch_queue #(.DEPTH(DEPTH)) DUT (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({status_o, out_ident_o, out_pages_o, out_kind_o, out_rank_o,
                          waiting_count_o});
  end

  // sink side: random stall bursts, plus one long hold-off to back the queue up
  initial begin : sink_proc
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic req, input pjdq_pkg::job_t job);
    if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    job_ident_i  <= job.ident;
    page_count_i <= job.pages;
    job_kind_i   <= job.kind;
    job_rank_i   <= job.rank;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req, job);
  endtask

  initial begin : stimulus
    pjdq_pkg::job_t job;
    int             submit_pct;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dispatch, field extremes, tie breaks, full store
    send_word(pjdq_pkg::REQ_DISPATCH, '1);
    send_word(pjdq_pkg::REQ_SUBMIT,
              '{rank: 8'hFF, pages: 16'hFFFF, ident: 16'h0000, kind: 2'd0});
    send_word(pjdq_pkg::REQ_SUBMIT,
              '{rank: 8'h00, pages: 16'h0000, ident: 16'hFFFF, kind: 2'd3});
    send_word(pjdq_pkg::REQ_DISPATCH, '0);
    for (int i = 0; i < 15; i++) begin
      job.ident = 16'(16'h0100 + i);
      job.pages = 16'(i % 3);
      job.kind  = 2'(i);
      job.rank  = 8'(7 + i % 2);
      send_word(pjdq_pkg::REQ_SUBMIT, job);
    end
    send_word(pjdq_pkg::REQ_SUBMIT,
              '{rank: 8'h00, pages: 16'h0000, ident: 16'hFFFF, kind: 2'd3});
    repeat (4) send_word(pjdq_pkg::REQ_DISPATCH, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: submit_pct = 25;
          1: submit_pct = 55;
          default: submit_pct = 80;
        endcase
        gap_odds   = $urandom_range(0, 2) * 15;
        stall_odds = $urandom_range(0, 2) * 15;
      end
      // keep offering words while the sink holds off
      if (n == 0) begin
        gap_odds      = 0;
        long_hold_req = 1'b1;
      end
      if (n >= RANDOM_WORDS - QUIET_WORDS) begin
        gap_odds   = 0;
        stall_odds = 0;
      end
      job.ident = 16'($urandom);
      job.pages = 16'($urandom);
      job.kind  = 2'($urandom);
      job.rank  = 8'($urandom);
      // narrow keys so rank and page ties come up often
      if ($urandom_range(0, 1) == 1) begin
        job.rank  = 8'($urandom_range(0, 3));
        job.pages = 16'($urandom_range(0, 3));
      end
      send_word(($urandom_range(0, 99) < submit_pct) ? pjdq_pkg::REQ_SUBMIT
                                                      : pjdq_pkg::REQ_DISPATCH, job);
    end
    in_valid_i <= 1'b0;

    while (board.due_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/core/pjdq_pkg.sv
rtl/core/pjdq_cell.sv
rtl/core/priority_job_dispatch_queue.sv
rtl/core/pjdq_checker.sv
test/priority_job_dispatch_queue_tb.sv
